>>> src/tws_pkg.sv
// Shared types and constants for the two-wire sensor bus master.
`timescale 1ns / 1ps
package tws_pkg;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned TickW     = 16;
  localparam int unsigned PollW     = 10;
  localparam int unsigned StepW     = 6;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutDataW  = 16;
  localparam int unsigned CmdW      = 3;

  localparam logic [TickW-1:0] HalfPeriodRst   = 16'd10;
  localparam logic [TickW-1:0] PollIntervalRst = 16'd1000;
  localparam logic [PollW-1:0] PollLimitRst    = 10'd500;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgHalfPeriod   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPollInterval = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPollLimit    = 2'd2;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_RESET = 3'd5,
    CMD_WAIT  = 3'd6
  } tws_cmd_e;

  // Pin sequencer operations.
  typedef enum logic [3:0] {
    OP_END      = 4'd0,
    OP_SDA0     = 4'd1,
    OP_SDA1     = 4'd2,
    OP_SCL0     = 4'd3,
    OP_SCL1     = 4'd4,
    OP_HOLD     = 4'd5,
    OP_BIT      = 4'd6,
    OP_REL_HOLD = 4'd7,
    OP_SAMPLE   = 4'd8,
    OP_ACKBIT   = 4'd9
  } tws_op_e;

  // Pin level bit positions.
  localparam int unsigned PinScl = 0;
  localparam int unsigned PinSda = 1;
  localparam int unsigned PinDrv = 2;

endpackage

>>> src/two_wire_sensor_bus_master_core.sv
// Top level of the two-wire sensor bus master: command/tick stream in, pin state out.
`timescale 1ns / 1ps
// An accepted item's result is registered in the output register. Throughput: one item
// per clock unless results stall; the sequence table lookup and one pin update sit
// between the state registers, and the output register parts the two stream sides.
// Reset (rst_ni low, asynchronous) idles the sequencer, drives clock low and data high,
// restores the register defaults (hold 10, poll interval 1000, poll limit 500).
module two_wire_sensor_bus_master_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata: data_byte [7:0], send_ack [8], sda_in [9], zero fill [15:10].
  input  logic [tws_pkg::InDataW-1:0]   s_axis_tdata_i,
  // tuser: opcode [2:0].
  input  logic [tws_pkg::CmdW-1:0]      s_axis_tuser_i,
  // Result stream.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tdata: scl_out [0], sda_out [1], sda_drive [2], busy_res [3], done_res [4],
  // read_byte [12:5], ack_seen [13], rejected [14], zero fill [15].
  output logic [tws_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tws_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tws_pkg::TickW-1:0]     cfg_data_i
);
  import tws_pkg::*;

  // Configuration registers.
  logic [TickW-1:0] half_period_q;
  logic [TickW-1:0] poll_interval_q;
  logic [PollW-1:0] poll_limit_q;

  // Sequencer state.
  tws_cmd_e         cmd_q, cmd_d;
  logic [StepW-1:0] step_q, step_d;
  logic [ByteW-1:0] shift_q, shift_d;
  logic [TickW-1:0] delay_q, delay_d;
  logic [PollW-1:0] poll_q, poll_d;
  logic [2:0]       pins_q, pins_d;
  logic             ack_q, ack_d;
  logic [ByteW-1:0] last_read_q, last_read_d;
  logic             read_ack_q, read_ack_d;

  // Output register.
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic [OutDataW-1:0] out_data_d;

  // Input item fields.
  tws_cmd_e         in_cmd;
  logic [ByteW-1:0] in_byte;
  logic             in_send_ack;
  logic             in_sda;

  logic             accept;
  logic             is_command;
  logic             cmd_start;
  logic             done;
  logic             rejected;
  logic             run;

  // Operand selection for the sequencer step.
  tws_cmd_e         run_cmd;
  logic [StepW-1:0] run_step;
  logic [ByteW-1:0] run_shift;
  logic [2:0]       run_pins;
  tws_op_e          run_op;

  logic [TickW-1:0] hold_len;
  logic [TickW-1:0] poll_len;
  logic [PollW-1:0] poll_max;
  logic [TickW-1:0] delay_dec;
  logic [PollW-1:0] poll_inc;

  assign in_cmd      = tws_cmd_e'(s_axis_tuser_i);
  assign in_byte     = s_axis_tdata_i[ByteW-1:0];
  assign in_send_ack = s_axis_tdata_i[ByteW];
  assign in_sda      = s_axis_tdata_i[ByteW+1];

  // A new item is taken whenever the result register is free or being emptied.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // Zero in any timing register behaves as one.
  assign hold_len  = (half_period_q == '0) ? TickW'(1) : half_period_q;
  assign poll_len  = (poll_interval_q == '0) ? TickW'(1) : poll_interval_q;
  assign poll_max  = (poll_limit_q == '0) ? PollW'(1) : poll_limit_q;
  assign delay_dec = (delay_q != '0) ? (delay_q - TickW'(1)) : delay_q;
  assign poll_inc  = poll_q + PollW'(1);

  always_comb begin
    case (in_cmd)
      CMD_START, CMD_STOP, CMD_WRITE, CMD_READ, CMD_RESET: is_command = 1'b1;
      default:                                             is_command = 1'b0;
    endcase
  end

  // A non-wait command accepted while idle runs its first operation at once.
  assign cmd_start = accept && is_command && (cmd_q == CMD_TICK);

  always_comb begin
    if (cmd_start) begin
      run_cmd  = in_cmd;
      run_step = '0;
      run_pins = pins_q;
      run_pins[PinDrv] = (in_cmd != CMD_READ);
      if (in_cmd == CMD_WRITE) begin
        run_shift = in_byte;
      end else if (in_cmd == CMD_READ) begin
        run_shift = '0;
      end else begin
        run_shift = shift_q;
      end
    end else begin
      run_cmd   = cmd_q;
      run_step  = step_q;
      run_pins  = pins_q;
      run_shift = shift_q;
    end
  end

  tws_seq_rom u_seq_rom (
    .cmd_i  (run_cmd),
    .step_i (run_step),
    .op_o   (run_op)
  );

  // Next state for one accepted item.
  always_comb begin
    cmd_d       = cmd_q;
    step_d      = step_q;
    shift_d     = shift_q;
    delay_d     = delay_q;
    poll_d      = poll_q;
    pins_d      = pins_q;
    ack_d       = ack_q;
    last_read_d = last_read_q;
    read_ack_d  = read_ack_q;
    done        = 1'b0;
    rejected    = 1'b0;
    run         = 1'b0;

    if (accept) begin
      case (in_cmd)
        CMD_TICK: begin
          // Ticks count down the hold; when it runs out the next operation fires, or a wait polls.
          if (cmd_q != CMD_TICK) begin
            delay_d = delay_dec;
            if (delay_dec == '0) begin
              if (cmd_q == CMD_WAIT) begin
                poll_d = poll_inc;
                if (!in_sda || (poll_inc >= poll_max)) begin
                  ack_d = !in_sda;
                  cmd_d = CMD_TICK;
                  done  = 1'b1;
                end else begin
                  delay_d = poll_len;
                end
              end else begin
                run = 1'b1;
              end
            end
          end
        end
        CMD_START, CMD_STOP, CMD_WRITE, CMD_READ, CMD_RESET, CMD_WAIT: begin
          if (cmd_q != CMD_TICK) begin
            rejected = 1'b1;
          end else begin
            cmd_d  = in_cmd;
            step_d = '0;
            if (in_cmd == CMD_WAIT) begin
              pins_d[PinDrv] = 1'b0;
              poll_d  = '0;
              delay_d = poll_len;
            end else begin
              if (in_cmd == CMD_READ) read_ack_d = in_send_ack;
              run = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    if (run) begin
      if (run_op == OP_END) begin
        if (run_cmd == CMD_READ) last_read_d = run_shift;
        cmd_d   = CMD_TICK;
        step_d  = '0;
        delay_d = '0;
        done    = 1'b1;
      end else begin
        pins_d  = run_pins;
        shift_d = run_shift;
        case (run_op)
          OP_SDA0: pins_d[PinSda] = 1'b0;
          OP_SDA1: pins_d[PinSda] = 1'b1;
          OP_SCL0: pins_d[PinScl] = 1'b0;
          OP_SCL1: pins_d[PinScl] = 1'b1;
          OP_BIT: begin
            pins_d[PinSda] = run_shift[ByteW-1];
            shift_d        = {run_shift[ByteW-2:0], 1'b0};
          end
          OP_REL_HOLD: pins_d[PinDrv] = 1'b0;
          OP_SAMPLE: begin
            // A write samples the slave acknowledge; a read shifts in a data bit.
            if (run_cmd == CMD_WRITE) begin
              ack_d = !in_sda;
            end else begin
              shift_d = {run_shift[ByteW-2:0], in_sda};
            end
            pins_d[PinScl] = 1'b0;
          end
          OP_ACKBIT: begin
            pins_d[PinDrv] = 1'b1;
            pins_d[PinSda] = !read_ack_q;
          end
          default: ;
        endcase
        step_d  = run_step + StepW'(1);
        delay_d = hold_len;
      end
    end
  end

  assign out_data_d = {1'b0, rejected, ack_d, last_read_d, done,
                       (cmd_d != CMD_TICK), pins_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q   <= HalfPeriodRst;
      poll_interval_q <= PollIntervalRst;
      poll_limit_q    <= PollLimitRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgHalfPeriod:   half_period_q   <= cfg_data_i;
        CfgPollInterval: poll_interval_q <= cfg_data_i;
        CfgPollLimit:    poll_limit_q    <= cfg_data_i[PollW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= CMD_TICK;
      step_q      <= '0;
      shift_q     <= '0;
      delay_q     <= '0;
      poll_q      <= '0;
      pins_q      <= 3'b110;
      ack_q       <= 1'b0;
      last_read_q <= '0;
      read_ack_q  <= 1'b0;
    end else if (accept) begin
      cmd_q       <= cmd_d;
      step_q      <= step_d;
      shift_q     <= shift_d;
      delay_q     <= delay_d;
      poll_q      <= poll_d;
      pins_q      <= pins_d;
      ack_q       <= ack_d;
      last_read_q <= last_read_d;
      read_ack_q  <= read_ack_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef SYNTH
  // A finished command never reports busy in the same result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[4]) |-> !out_data_q[3])
    else $error("done reported while busy");

  // A rejected command only happens while a sequence is running, which keeps running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[14]) |-> out_data_q[3])
    else $error("rejection reported while idle");

  // The idle sequencer always sits at its first step with no hold pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_q == CMD_TICK) |-> ((step_q == '0) && (delay_q == '0)))
    else $error("idle sequencer with stale step or hold");
`endif

endmodule

>>> src/tws_seq_rom.sv
// Sequence table: maps the active command and its step to a pin operation.
`timescale 1ns / 1ps
module tws_seq_rom (
  input  tws_pkg::tws_cmd_e             cmd_i,
  input  logic [tws_pkg::StepW-1:0]     step_i,
  output tws_pkg::tws_op_e              op_o
);
  import tws_pkg::*;

  logic [3:0]      bit_sum;
  logic [1:0]      phase;
  logic [2:0]      start_idx;
  logic [StepW-1:0] reset_off;

  // Start condition pattern, also used by the tail of the bus reset.
  function automatic tws_op_e start_op(logic [2:0] idx);
    tws_op_e res;
    case (idx)
      3'd0:    res = OP_SDA1;
      3'd1:    res = OP_SCL1;
      3'd2:    res = OP_SDA0;
      3'd3:    res = OP_SCL0;
      3'd4:    res = OP_SCL1;
      3'd5:    res = OP_SDA1;
      default: res = OP_SCL0;
    endcase
    return res;
  endfunction

  // Step modulo three: even bit weights are 1 and odd ones 2 (mod 3).
  assign bit_sum = {2'b00, step_i[0]} + {2'b00, step_i[2]} + {2'b00, step_i[4]}
                 + {1'b0, step_i[1], 1'b0} + {1'b0, step_i[3], 1'b0}
                 + {1'b0, step_i[5], 1'b0};

  always_comb begin
    case (bit_sum)
      4'd0, 4'd3, 4'd6, 4'd9: phase = 2'd0;
      4'd1, 4'd4, 4'd7:       phase = 2'd1;
      default:                phase = 2'd2;
    endcase
  end

  assign reset_off = step_i - StepW'(27);
  assign start_idx = reset_off[2:0];

  always_comb begin
    op_o = OP_END;
    case (cmd_i)
      CMD_START: begin
        if (step_i < StepW'(7)) op_o = start_op(step_i[2:0]);
      end
      CMD_STOP: begin
        if (step_i == StepW'(0))      op_o = OP_SDA0;
        else if (step_i == StepW'(1)) op_o = OP_SCL1;
        else if (step_i == StepW'(2)) op_o = OP_SDA1;
      end
      CMD_WRITE: begin
        if (step_i < StepW'(24)) begin
          op_o = (phase == 2'd0) ? OP_BIT : ((phase == 2'd1) ? OP_SCL1 : OP_SCL0);
        end else if (step_i == StepW'(24)) begin
          op_o = OP_REL_HOLD;
        end else if (step_i == StepW'(25)) begin
          op_o = OP_SCL1;
        end else if (step_i == StepW'(26)) begin
          op_o = OP_SAMPLE;
        end
      end
      CMD_READ: begin
        if (step_i < StepW'(24)) begin
          op_o = (phase == 2'd0) ? OP_HOLD : ((phase == 2'd1) ? OP_SCL1 : OP_SAMPLE);
        end else if (step_i == StepW'(24)) begin
          op_o = OP_ACKBIT;
        end else if (step_i == StepW'(25)) begin
          op_o = OP_SCL1;
        end else if (step_i == StepW'(26)) begin
          op_o = OP_SCL0;
        end
      end
      CMD_RESET: begin
        if (step_i < StepW'(27)) begin
          op_o = (phase == 2'd0) ? OP_SDA1 : ((phase == 2'd1) ? OP_SCL1 : OP_SCL0);
        end else if (step_i < StepW'(34)) begin
          op_o = start_op(start_idx);
        end else if (step_i == StepW'(34)) begin
          op_o = OP_SCL1;
        end
      end
      default: op_o = OP_END;
    endcase
  end

endmodule

>>> tb/tb_two_wire_sensor_bus_master_core.sv
// Self-checking testbench for the two-wire sensor bus master core.
`timescale 1ns / 1ps
package tb_bus_master_pkg;
  import tws_pkg::*;

  // Opcode seven has no command behind it and must leave the state alone.
  localparam logic [CmdW-1:0] NoOpcode = 3'd7;
  // Register index three decodes to nothing.
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  // Step layout of the sequenced commands.
  localparam int unsigned ByteSteps  = 24;
  localparam int unsigned OnesSteps  = 27;
  localparam int unsigned StartSteps = 7;
  localparam int unsigned StopSteps  = 3;

  // How the data line behaves on the ticks of one command.
  typedef enum int unsigned {
    LINE_RANDOM,
    LINE_HIGH,
    LINE_LOW,
    LINE_MOSTLY_HIGH
  } line_mode_e;

  // Result word, laid out like the result tdata from bit 14 down to bit 0.
  typedef struct packed {
    logic       rejected;
    logic       ack_seen;
    logic [7:0] read_byte;
    logic       done;
    logic       busy;
    logic       sda_drive;
    logic       sda_out;
    logic       scl_out;
  } pin_result_t;

  class pin_scoreboard;
    bit [TickW-1:0] half_period;
    bit [TickW-1:0] poll_interval;
    bit [PollW-1:0] poll_limit;
    bit [CmdW-1:0]  active_cmd;
    bit [StepW-1:0] step;
    bit [ByteW-1:0] shifter;
    bit [TickW-1:0] hold_left;
    bit [PollW-1:0] polls_done;
    bit             scl;
    bit             sda;
    bit             drv;
    bit             ack;
    bit [ByteW-1:0] last_read;
    bit             read_ack_req;
    pin_result_t    expected_pins[$];
    int unsigned    results_seen;
    int unsigned    errors;

    function new();
      half_period   = HalfPeriodRst;
      poll_interval = PollIntervalRst;
      poll_limit    = PollLimitRst;
      active_cmd    = CMD_TICK;
      step          = '0;
      shifter       = '0;
      hold_left     = '0;
      polls_done    = '0;
      scl           = 1'b0;
      sda           = 1'b1;
      drv           = 1'b1;
      ack           = 1'b0;
      last_read     = '0;
      read_ack_req  = 1'b0;
      results_seen  = 0;
      errors        = 0;
    endfunction

    function void set_reg(bit [CfgIdxW-1:0] index, bit [TickW-1:0] value);
      case (index)
        CfgHalfPeriod:   half_period = value;
        CfgPollInterval: poll_interval = value;
        CfgPollLimit:    poll_limit = value[PollW-1:0];
        default: ;
      endcase
    endfunction

    function bit busy();
      return active_cmd != CMD_TICK;
    endfunction

    function int unsigned pending();
      return expected_pins.size();
    endfunction

    // A register value of zero behaves as one.
    function bit [TickW-1:0] hold_ticks();
      return (half_period == 0) ? TickW'(1) : half_period;
    endfunction

    function bit [TickW-1:0] poll_ticks();
      return (poll_interval == 0) ? TickW'(1) : poll_interval;
    endfunction

    function bit [PollW-1:0] max_polls();
      return (poll_limit == 0) ? PollW'(1) : poll_limit;
    endfunction

    function tws_op_e start_op(int unsigned idx);
      case (idx)
        0:       return OP_SDA1;
        1:       return OP_SCL1;
        2:       return OP_SDA0;
        3:       return OP_SCL0;
        4:       return OP_SCL1;
        5:       return OP_SDA1;
        default: return OP_SCL0;
      endcase
    endfunction

    // Pin operation at the current step of the running command.
    function tws_op_e next_op();
      case (active_cmd)
        CMD_START: return (step < StartSteps) ? start_op(int'(step)) : OP_END;
        CMD_STOP: begin
          if (step == 0) return OP_SDA0;
          if (step == 1) return OP_SCL1;
          if (step == 2) return OP_SDA1;
          return OP_END;
        end
        CMD_WRITE: begin
          if (step < ByteSteps) begin
            case (step % 3)
              0:       return OP_BIT;
              1:       return OP_SCL1;
              default: return OP_SCL0;
            endcase
          end
          if (step == ByteSteps)     return OP_REL_HOLD;
          if (step == ByteSteps + 1) return OP_SCL1;
          if (step == ByteSteps + 2) return OP_SAMPLE;
          return OP_END;
        end
        CMD_READ: begin
          if (step < ByteSteps) begin
            case (step % 3)
              0:       return OP_HOLD;
              1:       return OP_SCL1;
              default: return OP_SAMPLE;
            endcase
          end
          if (step == ByteSteps)     return OP_ACKBIT;
          if (step == ByteSteps + 1) return OP_SCL1;
          if (step == ByteSteps + 2) return OP_SCL0;
          return OP_END;
        end
        CMD_RESET: begin
          if (step < OnesSteps) begin
            case (step % 3)
              0:       return OP_SDA1;
              1:       return OP_SCL1;
              default: return OP_SCL0;
            endcase
          end
          if (step < OnesSteps + StartSteps) return start_op(step - OnesSteps);
          if (step == OnesSteps + StartSteps) return OP_SCL1;
          return OP_END;
        end
        default: return OP_END;
      endcase
    endfunction

    // Carries out one pin operation; returns 1 when the command is complete.
    function bit run_op(bit sda_in);
      tws_op_e op;
      op = next_op();
      case (op)
        OP_END: begin
          if (active_cmd == CMD_READ) last_read = shifter;
          active_cmd = CMD_TICK;
          step       = '0;
          hold_left  = '0;
          return 1'b1;
        end
        OP_SDA0: sda = 1'b0;
        OP_SDA1: sda = 1'b1;
        OP_SCL0: scl = 1'b0;
        OP_SCL1: scl = 1'b1;
        OP_BIT: begin
          sda     = shifter[7];
          shifter = shifter << 1;
        end
        OP_REL_HOLD: drv = 1'b0;
        OP_SAMPLE: begin
          if (active_cmd == CMD_WRITE) begin
            ack = !sda_in;
          end else begin
            shifter = {shifter[6:0], sda_in};
          end
          scl = 1'b0;
        end
        OP_ACKBIT: begin
          drv = 1'b1;
          sda = !read_ack_req;
        end
        default: ;
      endcase
      step      = step + StepW'(1);
      hold_left = hold_ticks();
      return 1'b0;
    endfunction

    // Advances the predicted state by one accepted item and queues the pin result.
    function void predict_pins(bit [CmdW-1:0] opcode, bit [ByteW-1:0] data, bit sack,
                               bit sda_in);
      pin_result_t want;
      bit          done;
      bit          rej;
      done = 1'b0;
      rej  = 1'b0;
      if (opcode == CMD_TICK) begin
        if (busy()) begin
          if (hold_left > 0) hold_left = hold_left - TickW'(1);
          if (hold_left == 0) begin
            if (active_cmd == CMD_WAIT) begin
              polls_done = polls_done + PollW'(1);
              if (!sda_in || polls_done >= max_polls()) begin
                ack        = !sda_in;
                active_cmd = CMD_TICK;
                done       = 1'b1;
              end else begin
                hold_left = poll_ticks();
              end
            end else begin
              done = run_op(sda_in);
            end
          end
        end
      end else if (opcode != NoOpcode) begin
        if (busy()) begin
          rej = 1'b1;
        end else begin
          active_cmd = opcode;
          step       = '0;
          if (opcode == CMD_WAIT) begin
            drv        = 1'b0;
            polls_done = '0;
            hold_left  = poll_ticks();
          end else begin
            if (opcode == CMD_WRITE) shifter = data;
            if (opcode == CMD_READ) begin
              shifter      = '0;
              read_ack_req = sack;
              drv          = 1'b0;
            end else begin
              drv = 1'b1;
            end
            void'(run_op(sda_in));
          end
        end
      end
      want.scl_out   = scl;
      want.sda_out   = sda;
      want.sda_drive = drv;
      want.busy      = busy();
      want.done      = done;
      want.read_byte = last_read;
      want.ack_seen  = ack;
      want.rejected  = rej;
      expected_pins.push_back(want);
    endfunction

    task report(string msg);
      if (errors < 50) $display("mismatch: %s", msg);
      errors++;
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %0h, expected %0h", results_seen, name, got,
                         want));
    endtask

    task check_result(logic [OutDataW-1:0] tdata);
      pin_result_t got;
      pin_result_t want;
      got = tdata[14:0];
      results_seen++;
      if (expected_pins.size() == 0) begin
        report($sformatf("result %0d arrived with no item waiting", results_seen));
        return;
      end
      want = expected_pins.pop_front();
      compare_field("scl_out", 8'(got.scl_out), 8'(want.scl_out));
      compare_field("sda_out", 8'(got.sda_out), 8'(want.sda_out));
      compare_field("sda_drive", 8'(got.sda_drive), 8'(want.sda_drive));
      compare_field("busy", 8'(got.busy), 8'(want.busy));
      compare_field("done", 8'(got.done), 8'(want.done));
      compare_field("read_byte", got.read_byte, want.read_byte);
      compare_field("ack_seen", 8'(got.ack_seen), 8'(want.ack_seen));
      compare_field("rejected", 8'(got.rejected), 8'(want.rejected));
    endtask
  endclass

endpackage

module tb_two_wire_sensor_bus_master_core;
  import tws_pkg::*;
  import tb_bus_master_pkg::*;

  // Cycles without any transfer on any channel before the run is declared hung.
  // The longest legal quiet stretch is a sender gap plus a receiver stall, so this
  // leaves a wide margin.
  localparam int unsigned StallLimit  = 1000;
  // Cycles allowed after the last result for anything stray to show up.
  localparam int unsigned DrainCycles = 8;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [InDataW-1:0]  in_data   = '0;
  logic [CmdW-1:0]     in_user   = '0;
  logic                res_valid;
  logic                res_ready = 1'b0;
  logic [OutDataW-1:0] res_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [TickW-1:0]    cfg_data  = '0;

  // Random idling on the input side (gaps) and the result side (stalls).
  bit             gaps_on;
  bit             stalls_on;
  int unsigned    items_sent;
  pin_scoreboard  board;

  two_wire_sensor_bus_master_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_user),
    .m_axis_tvalid_o (res_valid),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_o  (res_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Every accepted result is checked against the oldest predicted one. Sampling
  // happens at the rising edge, before any of this edge's updates land.
  always @(posedge clk) begin
    if (rst_n && res_valid && res_ready) board.check_result(res_data);
  end

  // The result side stalls in random bursts while stalls are enabled.
  initial begin : result_sink
    wait (rst_n);
    @(posedge clk);
    res_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stalls_on && $urandom_range(0, 9) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        res_ready <= 1'b1;
      end
    end
  end

  // Ends the run when no transfer of any kind happens for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (res_valid && res_ready) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Presents one item and holds it until the transfer completes. Valid is left
  // high so that back-to-back items stream without a bubble.
  task automatic send_item(logic [CmdW-1:0] opcode, logic [ByteW-1:0] data, logic sack,
                           logic sda_in);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_user  <= opcode;
    in_data  <= {{(InDataW - ByteW - 2){1'b0}}, sda_in, sack, data};
    do @(posedge clk); while (!in_ready);
    board.predict_pins(opcode, data, sack, sda_in);
    items_sent++;
  endtask

  // Drops valid and waits until every predicted result has been checked.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // Leaves valid high; the caller lowers it once its writes are done.
  task automatic write_reg(logic [CfgIdxW-1:0] index, logic [TickW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(index, value);
  endtask

  // Phase boundary: the stream goes quiet, then the selected registers are
  // written. A command may still be running; new values apply from its next hold.
  task automatic begin_phase(logic [TickW-1:0] half, logic [TickW-1:0] interval,
                             logic [TickW-1:0] limit, logic [3:0] which);
    wait_drained();
    if (which[0]) write_reg(CfgHalfPeriod, half);
    if (which[1]) write_reg(CfgPollInterval, interval);
    if (which[2]) write_reg(CfgPollLimit, limit);
    if (which[3]) write_reg(CfgSpare, TickW'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic line_level(line_mode_e mode);
    case (mode)
      LINE_HIGH:        return 1'b1;
      LINE_LOW:         return 1'b0;
      LINE_MOSTLY_HIGH: return $urandom_range(0, 7) != 0;
      default:          return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // Ticks until the running command is over. Now and then a stray command or
  // an opcode seven is slipped in; the block must reject or ignore it.
  task automatic finish_command(line_mode_e mode);
    while (board.busy()) begin
      if ($urandom_range(0, 15) == 0)
        send_item(CmdW'($urandom_range(CMD_START, NoOpcode)), ByteW'($urandom),
                  1'($urandom), 1'($urandom));
      else
        send_item(CMD_TICK, ByteW'($urandom), 1'($urandom), line_level(mode));
    end
  endtask

  task automatic run_command(logic [CmdW-1:0] opcode, logic [ByteW-1:0] data, logic sack,
                             line_mode_e mode);
    send_item(opcode, data, sack, 1'($urandom));
    finish_command(mode);
  endtask

  // Mostly whole commands with random content; a tenth of the time a lone
  // random item, which may leave a command half done for the next one to hit.
  task automatic random_traffic(int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0)
        send_item(CmdW'($urandom_range(CMD_TICK, NoOpcode)), ByteW'($urandom),
                  1'($urandom), 1'($urandom));
      else
        run_command(CmdW'($urandom_range(CMD_START, CMD_WAIT)), ByteW'($urandom),
                    1'($urandom),
                    line_mode_e'($urandom_range(LINE_RANDOM, LINE_MOSTLY_HIGH)));
    end
  endtask

  initial begin : stimulus
    board      = new();
    gaps_on    = 1'b1;
    stalls_on  = 1'b1;
    items_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values in force (hold of ten). Idle ticks and opcode seven change
    // nothing; a start is then hit by every command and by opcode seven.
    send_item(CMD_TICK, 8'hFF, 1'b1, 1'b1);
    send_item(NoOpcode, 8'hFF, 1'b1, 1'b1);
    send_item(CMD_TICK, 8'h00, 1'b0, 1'b0);
    send_item(CMD_START, 8'h00, 1'b0, 1'b1);
    send_item(CMD_STOP, 8'hFF, 1'b1, 1'b0);
    send_item(CMD_WRITE, 8'hA5, 1'b0, 1'b1);
    send_item(CMD_READ, 8'h00, 1'b1, 1'b0);
    send_item(CMD_RESET, 8'hFF, 1'b0, 1'b1);
    send_item(CMD_WAIT, 8'h5A, 1'b1, 1'b0);
    send_item(NoOpcode, 8'h00, 1'b0, 1'b0);
    send_item(CMD_START, 8'hFF, 1'b1, 1'b1);
    repeat (12) send_item(CMD_TICK, ByteW'($urandom), 1'($urandom), 1'($urandom));

    // A hold of zero acts as one; written while the start is still running.
    begin_phase(16'd0, 16'd0, 16'd0, 4'b0001);
    finish_command(LINE_RANDOM);
    run_command(CMD_WRITE, 8'hFF, 1'b0, LINE_LOW);
    run_command(CMD_WRITE, 8'h00, 1'b1, LINE_HIGH);
    run_command(CMD_READ, 8'h00, 1'b1, LINE_HIGH);
    run_command(CMD_READ, 8'hFF, 1'b0, LINE_LOW);
    run_command(CMD_RESET, ByteW'($urandom), 1'($urandom), LINE_RANDOM);
    run_command(CMD_STOP, ByteW'($urandom), 1'($urandom), LINE_RANDOM);
    // Short poll interval with the reset poll limit of five hundred in force.
    begin_phase(16'd0, 16'd3, 16'd0, 4'b0010);
    run_command(CMD_WAIT, ByteW'($urandom), 1'($urandom), LINE_RANDOM);

    // Register extremes, run back to back without idling to keep the run short.
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    // Widest values in every register, the spare index included.
    begin_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'b1111);
    // The poll limit write is masked down to its ten bits, which leaves three.
    begin_phase(16'd40, 16'd1, 16'hFC03, 4'b0111);
    send_item(CMD_WRITE, ByteW'($urandom), 1'b0, 1'b0);
    // The first hold runs out at full length; the rest use the new short hold.
    begin_phase(16'd1, 16'd0, 16'd0, 4'b0001);
    finish_command(LINE_RANDOM);
    // Every one of the three polls sees a high line, so the wait times out.
    run_command(CMD_WAIT, ByteW'($urandom), 1'($urandom), LINE_HIGH);
    // Long poll interval with a limit of zero, which acts as a single poll.
    begin_phase(16'd0, 16'd50, 16'd0, 4'b0110);
    run_command(CMD_WAIT, ByteW'($urandom), 1'($urandom), LINE_RANDOM);

    // Random phases with short holds and small poll settings. The last two run
    // without any idling on either side.
    for (int ph = 0; ph < 10; ph++) begin
      gaps_on   = (ph < 8) && ($urandom_range(0, 3) != 0);
      stalls_on = (ph < 8) && ($urandom_range(0, 3) != 0);
      begin_phase(TickW'($urandom_range(0, 3)), TickW'($urandom_range(0, 4)),
                  TickW'($urandom_range(0, 8)),
                  (ph == 0) ? 4'b0111 : 4'($urandom_range(0, 15)));
      random_traffic(80);
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
